FILE: sv/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared types and constants of the masked 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mmf_pkg;

    localparam int PIX_W    = 16;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int WCFG_W   = 11;
    localparam int HCFG_W   = 13;
    localparam int MAX_ROWS = 4096;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd1024;

    // register index codes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic             mask;
        logic [PIX_W-1:0] pix;
    } tap_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

FILE: sv/mmf_if.sv
// ----------------------------------------------------------------------------
// mmf_if
// Valid/ready stream channels: pixel input beats and filter result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mmf_pkg::PIX_W-1:0] pixel_value;
    logic                      mask_bit;

    modport source (output valid, output pixel_value, output mask_bit, input ready);
    modport sink   (input valid, input pixel_value, input mask_bit, output ready);
endinterface

interface mmf_res_if;
    logic                      valid;
    logic                      ready;
    logic [mmf_pkg::ROW_W-1:0] out_row;
    logic [mmf_pkg::COL_W-1:0] out_col;
    logic [mmf_pkg::PIX_W-1:0] out_value;
    logic                      last_of_run;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: sv/masked_median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// masked_median_filter_3x3_top
// Streaming 3x3 median filter with per-pixel mask, two line memories.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+------------------------------------
//  pix_in    | in  | valid/ready       | pixel_value[15:0], mask_bit
//  res_out   | out | valid/ready       | out_row[11:0], out_col[9:0],
//            |     |                   | out_value[15:0], last_of_run
//  apb       | in  | psel/penable      | paddr[2:0], pwdata/prdata[31:0]
//
//  One pixel beat per clock while input credits allow. Median: 3-stage network.
//  Line memories: read at accept, written back in the next cycle at the same
//  column; consecutive beats share a column only across a register write.
//  Input ready is credit based: each beat in flight reserves 4 result slots
//  in a 32-entry result queue, so a stalled res_out throttles pix_in.
//  Reset: counters, window and queue clear; line memories hold no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_median_filter_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mmf_pix_if.sink          pix_in,
    mmf_res_if.source        res_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int CW         = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int FIFO_DEPTH = 32;
    localparam int PW         = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [3:0]                 emit;
        logic                       use_med;
        logic [mmf_pkg::ROW_W-1:0]  row;
        logic [CW-1:0]              col;
    } meta_t;

    typedef logic [mmf_pkg::PIX_W-1:0] pix_t;

    function automatic pix_t pmin(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t pmax(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return pmax(pmin(a, b), pmin(pmax(a, b), c));
    endfunction

    // ---------------- configuration ----------------
    logic [mmf_pkg::WCFG_W-1:0] width_reg;
    logic [mmf_pkg::HCFG_W-1:0] height_reg;
    logic                       cfg_wr;
    logic [12:0]                wext;
    logic [CW-1:0]              wm1;
    logic [mmf_pkg::ROW_W-1:0]  hm1;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mmf_pkg::WIDTH_RESET;
            height_reg <= mmf_pkg::HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                mmf_pkg::REG_WIDTH:  width_reg  <= pwdata[mmf_pkg::WCFG_W-1:0];
                mmf_pkg::REG_HEIGHT: height_reg <= pwdata[mmf_pkg::HCFG_W-1:0];
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            mmf_pkg::REG_WIDTH:  prdata = {21'b0, width_reg};
            mmf_pkg::REG_HEIGHT: prdata = {19'b0, height_reg};
            default:             prdata = 32'b0;
        endcase
    end

    // effective size minus one
    always_comb
    begin
        wext = {2'b0, width_reg};
        if (wext < 13'd3)
            wm1 = CW'(2);
        else if (wext > 13'(MAX_WIDTH))
            wm1 = CW'(MAX_WIDTH - 1);
        else
            wm1 = CW'(wext - 13'd1);

        if (height_reg < 13'd3)
            hm1 = 12'd2;
        else if (height_reg > 13'(mmf_pkg::MAX_ROWS))
            hm1 = 12'(mmf_pkg::MAX_ROWS - 1);
        else
            hm1 = 12'(height_reg - 13'd1);
    end

    // ---------------- accept and position ----------------
    logic                      accept;
    logic [CW-1:0]             col_reg;
    logic [mmf_pkg::ROW_W-1:0] row_reg;
    logic [PW:0]               reserve_reg;
    logic [PW:0]               reserve_next;

    assign pix_in.ready = (reserve_reg <= (PW+1)'(FIFO_DEPTH - 4));
    assign accept       = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_wr)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_reg == wm1)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == hm1) ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ---------------- line memories ----------------
    mmf_pkg::tap_t upper_mem [MAX_WIDTH];
    mmf_pkg::tap_t lower_mem [MAX_WIDTH];
    mmf_pkg::tap_t upper_rd_reg;
    mmf_pkg::tap_t lower_rd_reg;

    logic                      s1_valid_reg;
    logic [mmf_pkg::ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]             s1_col_reg;
    mmf_pkg::tap_t             s1_cur_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_rd_reg <= upper_mem[col_reg];
            lower_rd_reg <= lower_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            upper_mem[s1_col_reg] <= lower_rd_reg;
            lower_mem[s1_col_reg] <= s1_cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg <= row_reg;
            s1_col_reg <= col_reg;
            s1_cur_reg <= {pix_in.mask_bit, pix_in.pixel_value};
        end
    end

    // ---------------- window and result flags ----------------
    mmf_pkg::tap_t window_reg  [9];
    mmf_pkg::tap_t window_next [9];
    meta_t         s1_meta;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            window_next[k*3 + 0] = window_reg[k*3 + 1];
            window_next[k*3 + 1] = window_reg[k*3 + 2];
        end
        window_next[2] = upper_rd_reg;
        window_next[5] = lower_rd_reg;
        window_next[8] = s1_cur_reg;

        s1_meta.row     = s1_row_reg;
        s1_meta.col     = s1_col_reg;
        s1_meta.use_med = (s1_row_reg > 12'd1) && (s1_col_reg > CW'(1));
        s1_meta.emit[0] = (s1_row_reg != '0) && (s1_col_reg != '0) && window_next[4].mask;
        s1_meta.emit[1] = (s1_row_reg != '0) && (s1_col_reg == wm1) && window_next[5].mask;
        s1_meta.emit[2] = (s1_row_reg == hm1) && (s1_col_reg != '0) && window_next[7].mask;
        s1_meta.emit[3] = (s1_row_reg == hm1) && (s1_col_reg == wm1) && s1_cur_reg.mask;
    end

    logic  s2_valid_reg, s3_valid_reg, s4_valid_reg;
    meta_t s2_meta_reg, s3_meta_reg, s4_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                window_reg[i] <= '0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg)
                window_reg <= window_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- median network ----------------
    pix_t s3_lo_reg [3];
    pix_t s3_mid_reg[3];
    pix_t s3_hi_reg [3];
    pix_t s4_a_reg, s4_b_reg, s4_c_reg;
    pix_t med_val;

    always_ff @(posedge clk)
    begin
        s2_meta_reg <= s1_meta;
        s3_meta_reg <= s2_meta_reg;
        s4_meta_reg <= s3_meta_reg;
        // sort each window row
        for (int k = 0; k < 3; k++)
        begin
            s3_lo_reg[k]  <= pmin(pmin(window_reg[k*3].pix, window_reg[k*3+1].pix),
                                  window_reg[k*3+2].pix);
            s3_hi_reg[k]  <= pmax(pmax(window_reg[k*3].pix, window_reg[k*3+1].pix),
                                  window_reg[k*3+2].pix);
            s3_mid_reg[k] <= med3(window_reg[k*3].pix, window_reg[k*3+1].pix,
                                  window_reg[k*3+2].pix);
        end
        s4_a_reg <= pmax(pmax(s3_lo_reg[0], s3_lo_reg[1]), s3_lo_reg[2]);
        s4_b_reg <= med3(s3_mid_reg[0], s3_mid_reg[1], s3_mid_reg[2]);
        s4_c_reg <= pmin(pmin(s3_hi_reg[0], s3_hi_reg[1]), s3_hi_reg[2]);
    end

    assign med_val = med3(s4_a_reg, s4_b_reg, s4_c_reg);

    // ---------------- result queue ----------------
    mmf_pkg::res_t cand [4];
    logic [1:0]    pos  [4];
    logic [2:0]    n_res;
    logic          push, pop;

    mmf_pkg::res_t fifo_mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign push = s4_valid_reg;
    assign pop  = res_out.valid && res_out.ready;

    always_comb
    begin
        cand[0].row   = s4_meta_reg.row - 12'd1;
        cand[0].col   = mmf_pkg::COL_W'(s4_meta_reg.col - CW'(1));
        cand[0].value = s4_meta_reg.use_med ? med_val : '0;
        cand[1].row   = s4_meta_reg.row - 12'd1;
        cand[1].col   = mmf_pkg::COL_W'(s4_meta_reg.col);
        cand[1].value = '0;
        cand[2].row   = s4_meta_reg.row;
        cand[2].col   = mmf_pkg::COL_W'(s4_meta_reg.col - CW'(1));
        cand[2].value = '0;
        cand[3].row   = s4_meta_reg.row;
        cand[3].col   = mmf_pkg::COL_W'(s4_meta_reg.col);
        cand[3].value = '0;
        cand[0].last  = (s4_meta_reg.emit[3:1] == 3'b0);
        cand[1].last  = (s4_meta_reg.emit[3:2] == 2'b0);
        cand[2].last  = !s4_meta_reg.emit[3];
        cand[3].last  = 1'b1;

        pos[0] = 2'd0;
        pos[1] = {1'b0, s4_meta_reg.emit[0]};
        pos[2] = pos[1] + {1'b0, s4_meta_reg.emit[1]};
        pos[3] = pos[2] + {1'b0, s4_meta_reg.emit[2]};
        n_res  = 3'($countones(s4_meta_reg.emit));

        reserve_next = reserve_reg;
        if (accept)
            reserve_next = reserve_next + (PW+1)'(4);
        if (push)
            reserve_next = reserve_next - (PW+1)'(3'd4 - n_res);
        if (pop)
            reserve_next = reserve_next - (PW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (push && s4_meta_reg.emit[i])
                fifo_mem[wr_ptr_reg + PW'(pos[i])] <= cand[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            reserve_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(n_res);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg   <= count_reg + (push ? (PW+1)'(n_res) : '0)
                           - (pop ? (PW+1)'(1) : '0);
            reserve_reg <= reserve_next;
        end
    end

    assign res_out.valid       = (count_reg != '0);
    assign res_out.out_row     = fifo_mem[rd_ptr_reg].row;
    assign res_out.out_col     = fifo_mem[rd_ptr_reg].col;
    assign res_out.out_value   = fifo_mem[rd_ptr_reg].value;
    assign res_out.last_of_run = fifo_mem[rd_ptr_reg].last;

endmodule

`default_nettype wire
